// ===== rtl/core/base64url_encoder_top_defines.svh =====
// Assertion macros shared by the base64url encoder RTL.
// Every macro expects clk and arst_n in scope at the point of use.
`ifndef BASE64URL_ENCODER_TOP_DEFINES_SVH
`define BASE64URL_ENCODER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define B64U_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define B64U_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/b64u_pkg.sv =====
// Package for the base64url encoder: group record type, queue sizing and alphabet.
// Used by every module in rtl/core; depends on nothing.
`default_nettype none

package b64u_pkg;

	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QPTR_W = 1;
	localparam int unsigned QCNT_W = 2;

	localparam logic [7:0] PAD_CHAR = 8'h3D;
	localparam logic [1:0] LAST_IDX = 2'd3;

	typedef struct packed {
		logic [3:0][5:0] sxt;
		logic [1:0]      npad;
		logic            last;
	} grp_t;

	function automatic logic [7:0] sym(input logic [5:0] v);
		logic [7:0] ch;
		if (v < 6'd26) begin
			ch = 8'h41 + {2'b00, v};
		end else if (v < 6'd52) begin
			ch = 8'h61 + {2'b00, v - 6'd26};
		end else if (v < 6'd62) begin
			ch = 8'h30 + {2'b00, v - 6'd52};
		end else if (v == 6'd62) begin
			ch = 8'h2D;
		end else begin
			ch = 8'h5F;
		end
		return ch;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/base64url_encoder_top.sv =====
// URL-safe base64 encoder. Bytes enter one per cycle with is_final on the message's
// last byte; each completed group of three bytes, or a final partial group, becomes
// a record in a two-entry queue, and the back end emits four characters per record,
// one per cycle while out_stall is low, with '=' padding and out_last on the fourth
// character of the final record. Sustained throughput is four characters per three
// bytes, set by the single character output register; a group's record passes
// through the queue and its first character then through the output register. Input
// stalls only while the queue is full.
`default_nettype none

module base64url_encoder_top (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [7:0] data_byte,
	input  wire logic       is_final,
	input  wire logic       in_valid,
	output logic            in_stall,
	output logic [7:0]      out_char,
	output logic            out_last,
	output logic            out_valid,
	input  wire logic       out_stall
);

	logic           q_full;
	logic           q_not_empty;
	logic           push;
	logic           pop;
	b64u_pkg::grp_t push_grp;
	b64u_pkg::grp_t head;

	b64u_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_byte (data_byte),
		.is_final  (is_final),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.q_full    (q_full),
		.push      (push),
		.push_grp  (push_grp)
	);

	b64u_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_grp  (push_grp),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (head)
	);

	b64u_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.grp_valid (q_not_empty),
		.grp       (head),
		.pop       (pop),
		.out_char  (out_char),
		.out_last  (out_last),
		.out_valid (out_valid),
		.out_stall (out_stall)
	);

endmodule

`default_nettype wire

// ===== rtl/core/b64u_front.sv =====
// Front part: accepts bytes, holds a partial group and builds a group record.
// Uses b64u_pkg; feeds the group queue.
`default_nettype none

module b64u_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [7:0]    data_byte,
	input  wire logic          is_final,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire logic          q_full,
	output logic               push,
	output b64u_pkg::grp_t     push_grp
);

	typedef enum logic [1:0] {PH_0, PH_1, PH_2} phase_t;

	phase_t     phase_q;
	logic [7:0] held0_q;
	logic [7:0] held1_q;
	logic       accept;

	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		push_grp = '0;
		push     = 1'b0;
		case (phase_q)
			PH_1: begin
				push_grp.sxt[0] = held0_q[7:2];
				push_grp.sxt[1] = {held0_q[1:0], data_byte[7:4]};
				push_grp.sxt[2] = {data_byte[3:0], 2'b00};
				push_grp.npad   = 2'd1;
				push_grp.last   = 1'b1;
				push            = accept && is_final;
			end
			PH_2: begin
				push_grp.sxt[0] = held0_q[7:2];
				push_grp.sxt[1] = {held0_q[1:0], held1_q[7:4]};
				push_grp.sxt[2] = {held1_q[3:0], data_byte[7:6]};
				push_grp.sxt[3] = data_byte[5:0];
				push_grp.npad   = 2'd0;
				push_grp.last   = is_final;
				push            = accept;
			end
			default: begin
				push_grp.sxt[0] = data_byte[7:2];
				push_grp.sxt[1] = {data_byte[1:0], 4'b0000};
				push_grp.npad   = 2'd2;
				push_grp.last   = 1'b1;
				push            = accept && is_final;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_0;
		end else if (accept) begin
			case (phase_q)
				PH_1: begin
					phase_q <= is_final ? PH_0 : PH_2;
				end
				PH_2: begin
					phase_q <= PH_0;
				end
				default: begin
					phase_q <= is_final ? PH_0 : PH_1;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !is_final) begin
			case (phase_q)
				PH_1: begin
					held1_q <= data_byte;
				end
				PH_2: begin
					held1_q <= held1_q;
				end
				default: begin
					held0_q <= data_byte;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/b64u_fifo.sv =====
// Short queue of group records between the front and back parts.
// Uses b64u_pkg and the assertion macros header.
`default_nettype none
`include "base64url_encoder_top_defines.svh"

module b64u_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  b64u_pkg::grp_t     push_grp,
	input  wire logic          pop,
	output logic               full,
	output logic               not_empty,
	output b64u_pkg::grp_t     head
);

	b64u_pkg::grp_t                    mem_q [b64u_pkg::QDEPTH];
	logic [b64u_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [b64u_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [b64u_pkg::QCNT_W-1:0]       count_q;

	assign full      = (count_q == b64u_pkg::QCNT_W'(b64u_pkg::QDEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_grp;
		end
	end

	`B64U_ASSERT_IMP(a_no_overflow, push, !full || pop, "Group queue written while full.")
	`B64U_ASSERT_IMP(a_no_underflow, pop, not_empty, "Group queue read while empty.")
	`B64U_ASSERT_NXT(a_count_up, push && !pop, count_q == $past(count_q) + 1'b1, "Queue count did not rise on a push.")

endmodule

`default_nettype wire

// ===== rtl/core/b64u_back.sv =====
// Back part: a group record gives four characters, one per unstalled cycle.
// Uses b64u_pkg and the assertion macros header; drives the output register.
`default_nettype none
`include "base64url_encoder_top_defines.svh"

module b64u_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          grp_valid,
	input  b64u_pkg::grp_t     grp,
	output logic               pop,
	output logic [7:0]         out_char,
	output logic               out_last,
	output logic               out_valid,
	input  wire logic          out_stall
);

	logic [1:0] idx_q;
	logic       load;
	logic [2:0] pad_sum;
	logic [7:0] next_char;

	assign load      = grp_valid && (!out_valid || !out_stall);
	assign pop       = load && (idx_q == b64u_pkg::LAST_IDX);
	assign pad_sum   = {1'b0, idx_q} + {1'b0, grp.npad};
	assign next_char = pad_sum[2] ? b64u_pkg::PAD_CHAR : b64u_pkg::sym(grp.sxt[idx_q]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (load) begin
				idx_q     <= idx_q + 1'b1;
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_char <= next_char;
			out_last <= grp.last && (idx_q == b64u_pkg::LAST_IDX);
		end
	end

	`B64U_ASSERT_IMP(a_group_held, idx_q != 2'd0, grp_valid, "Group record lost in mid-group.")
	`B64U_ASSERT_NXT(a_wrap, pop, idx_q == 2'd0, "Character index did not wrap after a group.")
	`B64U_ASSERT_NXT(a_last_pad, pop && grp.npad != 2'd0, out_char == b64u_pkg::PAD_CHAR && out_last, "Padded group did not end on a final pad.")

endmodule

`default_nettype wire
